FILE: rtl/bwu_pkg.sv
// Package for the breakpoint / watchpoint debug unit.
// Holds command, mode and status codes, the controller state type and the
// control struct between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bwu_pkg;

	localparam int CMD_W    = 3;
	localparam int ADDR_W   = 16;
	localparam int DATA_W   = 8;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;

	localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_STEP      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_ADD_BREAK = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ADD_WATCH = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CONTINUE  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_OBSERVE   = 3'd5;

	typedef enum logic [MODE_W-1:0] {
		MODE_INIT        = 2'd0,
		MODE_INTERACTIVE = 2'd1,
		MODE_RUNNING     = 2'd2
	} mode_t;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic load;   // capture item and table lookups
		logic exec;   // apply item, load result register
	} ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/bwu_ctrl.sv
// Controller for the debug unit: accept / execute sequencing and output valid.
// Depends on bwu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwu_ctrl import bwu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output ctrl_t ctrl
);

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		ctrl.load = (state_q == ST_IDLE) && in_valid;
		ctrl.exec = (state_q == ST_EXEC) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ctrl.exec)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/bwu_datapath.sv
// Datapath for the debug unit: breakpoint and watch tables, mode state,
// parallel address match and the result register. Depends on bwu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwu_datapath import bwu_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_t               ctrl,
	input  logic [CMD_W-1:0]    command,
	input  logic [ADDR_W-1:0]   address,
	input  logic [DATA_W-1:0]   data,
	input  logic [ADDR_W-1:0]   pc,
	output logic [STATUS_W-1:0] status,
	output logic                execute,
	output logic                break_hit,
	output logic                watch_changed,
	output logic [SLOT_W-1:0]   watch_slot,
	output logic [DATA_W-1:0]   old_value,
	output logic [MODE_W-1:0]   mode,
	output logic                verbose
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

	// tables
	logic [ADDR_W-1:0] brk_tab_q   [TABLE_ENTRIES];
	logic [ADDR_W-1:0] wch_tab_q   [TABLE_ENTRIES];
	logic [DATA_W-1:0] wch_val_q   [TABLE_ENTRIES];
	logic [CW-1:0]     brk_cnt_q;
	logic [CW-1:0]     wch_cnt_q;
	mode_t             mode_q;
	logic              verbose_q;

	// item capture
	logic [CMD_W-1:0]  cmd_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] data_s1;
	logic              brk_match_s1;
	logic              wch_match_s1;
	logic [IW-1:0]     wch_idx_s1;

	logic [ADDR_W-1:0] key;
	logic              brk_match;
	logic              wch_match;
	logic [IW-1:0]     wch_idx;

	always_comb begin
		key       = (command == CMD_TICK) ? pc : address;
		brk_match = 1'b0;
		wch_match = 1'b0;
		wch_idx   = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if ((CW'(i) < brk_cnt_q) && (brk_tab_q[i] == key))
				brk_match = 1'b1;
			if ((CW'(i) < wch_cnt_q) && (wch_tab_q[i] == address)) begin
				wch_match = 1'b1;
				wch_idx   = IW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_s1       <= command;
			addr_s1      <= address;
			data_s1      <= data;
			brk_match_s1 <= brk_match;
			wch_match_s1 <= wch_match;
			wch_idx_s1   <= wch_idx;
		end
	end

	// execute
	logic [STATUS_W-1:0] st_n;
	logic                ex_n;
	logic                hit_n;
	logic                chg_n;
	logic [DATA_W-1:0]   old_n;
	mode_t               mode_n;
	logic                verb_n;
	logic                brk_wr;
	logic                wch_wr;
	logic                val_wr;
	logic [DATA_W-1:0]   wch_cur;
	logic [IW+SLOT_W-1:0] slot_ext;

	assign wch_cur  = wch_val_q[wch_idx_s1];
	assign slot_ext = {{SLOT_W{1'b0}}, wch_idx_s1};

	always_comb begin
		st_n   = STAT_OK;
		ex_n   = 1'b0;
		hit_n  = 1'b0;
		chg_n  = 1'b0;
		old_n  = '0;
		mode_n = mode_q;
		verb_n = verbose_q;
		brk_wr = 1'b0;
		wch_wr = 1'b0;
		val_wr = 1'b0;
		case (mode_q)
			MODE_INIT, MODE_INTERACTIVE: begin
				case (cmd_s1)
					CMD_STEP: begin
						if (mode_q == MODE_INTERACTIVE)
							ex_n = 1'b1;
						else
							st_n = STAT_INVALID;
					end
					CMD_ADD_BREAK: begin
						if (!brk_match_s1) begin
							if (brk_cnt_q < FULL_CNT)
								brk_wr = 1'b1;
							else
								st_n = STAT_FULL;
						end
					end
					CMD_ADD_WATCH: begin
						if (!wch_match_s1) begin
							if (wch_cnt_q < FULL_CNT)
								wch_wr = 1'b1;
							else
								st_n = STAT_FULL;
						end
					end
					CMD_CONTINUE: begin
						mode_n = MODE_RUNNING;
						verb_n = 1'b0;
					end
					default: st_n = STAT_INVALID;
				endcase
			end
			MODE_RUNNING: begin
				case (cmd_s1)
					CMD_TICK: begin
						ex_n = 1'b1;
						if (brk_match_s1) begin
							hit_n  = 1'b1;
							mode_n = MODE_INTERACTIVE;
							verb_n = 1'b1;
						end
					end
					CMD_OBSERVE: begin
						if (wch_match_s1 && (wch_cur != data_s1)) begin
							chg_n  = 1'b1;
							old_n  = wch_cur;
							val_wr = 1'b1;
							mode_n = MODE_INTERACTIVE;
							verb_n = 1'b1;
						end
					end
					default: st_n = STAT_INVALID;
				endcase
			end
			default: st_n = STAT_INVALID;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_INIT;
			verbose_q <= 1'b0;
			brk_cnt_q <= '0;
			wch_cnt_q <= '0;
		end else if (ctrl.exec) begin
			mode_q    <= mode_n;
			verbose_q <= verb_n;
			if (brk_wr)
				brk_cnt_q <= brk_cnt_q + 1'b1;
			if (wch_wr)
				wch_cnt_q <= wch_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			if (brk_wr)
				brk_tab_q[brk_cnt_q[IW-1:0]] <= addr_s1;
			if (wch_wr) begin
				wch_tab_q[wch_cnt_q[IW-1:0]] <= addr_s1;
				wch_val_q[wch_cnt_q[IW-1:0]] <= data_s1;
			end
			if (val_wr)
				wch_val_q[wch_idx_s1] <= data_s1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			status        <= st_n;
			execute       <= ex_n;
			break_hit     <= hit_n;
			watch_changed <= chg_n;
			watch_slot    <= chg_n ? slot_ext[SLOT_W-1:0] : '0;
			old_value     <= old_n;
			mode          <= mode_n;
			verbose       <= verb_n;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/breakpoint_watchpoint_unit_core.sv
// Top level of the breakpoint / watchpoint debug unit.
// Instantiates bwu_ctrl and bwu_datapath; depends on bwu_pkg.
//
//   channel | direction | handshake            | fields
//   in      | input     | in_valid / in_ready   | command, address, data, pc
//   out     | output    | out_valid / out_ready | status, execute, break_hit,
//           |           |                       | watch_changed, watch_slot,
//           |           |                       | old_value, mode, verbose
//
// Each item is accepted, which latches the item and the parallel table match,
// and then executed, which applies it and loads the result register.
// A held result stalls the execute step; no new item is accepted meanwhile.
// Reset clears mode, verbose and both table counts; table contents are not
// cleared and only entries below the count are ever matched.
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_watchpoint_unit_core import bwu_pkg::*; #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [ADDR_W-1:0]   address,
	input  logic [DATA_W-1:0]   data,
	input  logic [ADDR_W-1:0]   pc,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic                execute,
	output logic                break_hit,
	output logic                watch_changed,
	output logic [SLOT_W-1:0]   watch_slot,
	output logic [DATA_W-1:0]   old_value,
	output logic [MODE_W-1:0]   mode,
	output logic                verbose
);

	ctrl_t ctrl;

	bwu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	bwu_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.command       (command),
		.address       (address),
		.data          (data),
		.pc            (pc),
		.status        (status),
		.execute       (execute),
		.break_hit     (break_hit),
		.watch_changed (watch_changed),
		.watch_slot    (watch_slot),
		.old_value     (old_value),
		.mode          (mode),
		.verbose       (verbose)
	);

endmodule

`default_nettype wire

FILE: rtl/bwu_checker.sv
// Port-level checks for the debug unit, bound to the top level.
// Depends on bwu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bwu_checker import bwu_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic                execute,
	input logic                break_hit,
	input logic                watch_changed,
	input logic [MODE_W-1:0]   mode,
	input logic                verbose
);

	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after accept");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(mode))
		else $error("stalled result changed");

	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && break_hit |-> execute && verbose && (mode == MODE_INTERACTIVE))
		else $error("breakpoint hit without interactive mode");

	a_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && watch_changed |-> verbose && (mode == MODE_INTERACTIVE)
			&& (status == STAT_OK))
		else $error("watch change without interactive mode");

	a_bad_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> !execute && !break_hit && !watch_changed)
		else $error("error status with side effects");

endmodule

bind breakpoint_watchpoint_unit_core bwu_checker u_bwu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.execute       (execute),
	.break_hit     (break_hit),
	.watch_changed (watch_changed),
	.mode          (mode),
	.verbose       (verbose)
);

`default_nettype wire
